// ----- rtl/assert_macros.svh -----
// assertion macros for the scaler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/spf_pkg.sv -----
// shared types, constants and pixel conversion for the scaled pixel fetch converter
package spf_pkg;

	localparam int OUT_WIDTH  = 320;
	localparam int OUT_HEIGHT = 240;
	localparam int BAND_LINES = 16;

	localparam int FRAC_BITS    = 16;
	localparam int SRC_WIDTH_W  = 11;
	localparam int SRC_HEIGHT_W = 10;
	localparam int STRIDE_W     = 12;
	localparam int PIXEL_W      = 16;
	localparam int ADDR_W       = 20;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = SRC_WIDTH_W'(320);
	localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST = SRC_HEIGHT_W'(240);
	localparam logic [STRIDE_W-1:0]     STRIDE_RST     = STRIDE_W'(1024);

	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE   = CFG_INDEX_W'(2);

	localparam int COL_W  = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
	localparam int LINE_W = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;
	localparam int BAND_W = (BAND_LINES > 1) ? $clog2(BAND_LINES) : 1;

	// horizontal step: source_width * 2^16 / OUT_WIDTH via reciprocal multiply
	localparam longint unsigned COL_STEP_MAX =
		(((64'd1 << SRC_WIDTH_W) - 64'd1) << FRAC_BITS) / OUT_WIDTH;
	localparam int COL_STEP_W = $clog2(COL_STEP_MAX + 64'd1);
	localparam longint unsigned COL_ACC_MAX = (OUT_WIDTH - 1) * COL_STEP_MAX;
	localparam int COL_ACC_RAW = $clog2(COL_ACC_MAX + 64'd1);
	localparam int COL_ACC_W   = (COL_ACC_RAW > FRAC_BITS) ? COL_ACC_RAW : FRAC_BITS + 1;
	localparam int COL_IDX_W   = COL_ACC_W - FRAC_BITS;
	localparam int COL_K       = SRC_WIDTH_W + $clog2(OUT_WIDTH);
	localparam longint unsigned COL_RECIP =
		((64'd1 << (FRAC_BITS + COL_K)) + OUT_WIDTH - 1) / OUT_WIDTH;
	localparam int COL_RECIP_W = $clog2(COL_RECIP + 64'd1);
	localparam int COL_PROD_W  = SRC_WIDTH_W + COL_RECIP_W + 2;

	// vertical step: source_height * 2^16 / OUT_HEIGHT
	localparam longint unsigned LINE_STEP_MAX =
		(((64'd1 << SRC_HEIGHT_W) - 64'd1) << FRAC_BITS) / OUT_HEIGHT;
	localparam int LINE_STEP_W = $clog2(LINE_STEP_MAX + 64'd1);
	localparam longint unsigned LINE_ACC_MAX = (OUT_HEIGHT - 1) * LINE_STEP_MAX;
	localparam int LINE_ACC_RAW = $clog2(LINE_ACC_MAX + 64'd1);
	localparam int LINE_ACC_W   = (LINE_ACC_RAW > FRAC_BITS) ? LINE_ACC_RAW : FRAC_BITS + 1;
	localparam int LINE_IDX_W   = LINE_ACC_W - FRAC_BITS;
	localparam int LINE_K       = SRC_HEIGHT_W + $clog2(OUT_HEIGHT);
	localparam longint unsigned LINE_RECIP =
		((64'd1 << (FRAC_BITS + LINE_K)) + OUT_HEIGHT - 1) / OUT_HEIGHT;
	localparam int LINE_RECIP_W = $clog2(LINE_RECIP + 64'd1);
	localparam int LINE_PROD_W  = SRC_HEIGHT_W + LINE_RECIP_W + 2;

	localparam int ADDR_PROD_W = LINE_IDX_W + STRIDE_W;
	localparam int ADDR_SUM_W  = ((ADDR_PROD_W > COL_IDX_W) ? ADDR_PROD_W : COL_IDX_W) + 1;
	localparam int ADDR_FULL_W = (ADDR_SUM_W > ADDR_W) ? ADDR_SUM_W : ADDR_W;

	localparam int OUT_FIELDS_W = ADDR_W + PIXEL_W + 2;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		OP_START = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic {
		KIND_REQ = 1'b0,
		KIND_PIX = 1'b1
	} kind_t;

	typedef struct packed {
		logic [SRC_WIDTH_W-1:0]  source_width;
		logic [SRC_HEIGHT_W-1:0] source_height;
		logic [STRIDE_W-1:0]     line_stride;
	} cfg_t;

	typedef struct packed {
		logic                  pix_valid;
		logic                  req_valid;
		logic [PIXEL_W-1:0]    pixel;
		logic                  band_end;
		logic                  frame_end;
		logic [LINE_IDX_W-1:0] row;
		logic [COL_IDX_W-1:0]  col;
	} res_t;

	typedef struct packed {
		logic pix_taken;
		logic req_taken;
	} drain_t;

	// 5-5-5 to 5-6-5 with green top bit replicated, bytes swapped
	function automatic logic [PIXEL_W-1:0] convert_pixel(input logic [PIXEL_W-1:0] c);
		logic [4:0]         r;
		logic [4:0]         g5;
		logic [4:0]         b;
		logic [PIXEL_W-1:0] v;
		r  = c[4:0];
		g5 = c[9:5];
		b  = c[14:10];
		v  = {b, g5, g5[4], r};
		return {v[7:0], v[15:8]};
	endfunction

endpackage

// ----- rtl/spf_cfg_regs.sv -----
// configuration registers for source size and line stride
module spf_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [spf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output spf_pkg::cfg_t                   cfg
);
	import spf_pkg::*;

	logic [SRC_WIDTH_W-1:0]  source_width_q;
	logic [SRC_HEIGHT_W-1:0] source_height_q;
	logic [STRIDE_W-1:0]     line_stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= SRC_WIDTH_RST;
			source_height_q <= SRC_HEIGHT_RST;
			line_stride_q   <= STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data[SRC_WIDTH_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data[SRC_HEIGHT_W-1:0];
				REG_LINE_STRIDE:   line_stride_q   <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{source_width: source_width_q, source_height: source_height_q,
		line_stride: line_stride_q};

endmodule

// ----- rtl/spf_frame_walker.sv -----
// input register, raster walk with step accumulators and result register
module spf_frame_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spf_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  spf_pkg::op_t                in_op,
	input  logic [spf_pkg::PIXEL_W-1:0] in_pixel,
	input  spf_pkg::drain_t             drain,
	output spf_pkg::res_t               res
);
	import spf_pkg::*;

	logic               valid_s1;
	op_t                op_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	res_t               res_s2;

	logic                   active_q;
	logic [COL_W-1:0]       out_column_q;
	logic [LINE_W-1:0]      out_line_q;
	logic [BAND_W-1:0]      band_line_q;
	logic [COL_ACC_W-1:0]   col_acc_q;
	logic [LINE_ACC_W-1:0]  line_acc_q;
	logic [COL_STEP_W-1:0]  col_step_q;
	logic [LINE_STEP_W-1:0] line_step_q;

	logic                   active_n;
	logic [COL_W-1:0]       out_column_n;
	logic [LINE_W-1:0]      out_line_n;
	logic [BAND_W-1:0]      band_line_n;
	logic [COL_ACC_W-1:0]   col_acc_n;
	logic [LINE_ACC_W-1:0]  line_acc_n;
	logic [COL_STEP_W-1:0]  col_step_n;
	logic [LINE_STEP_W-1:0] line_step_n;
	res_t                   res_n;

	logic [COL_PROD_W-1:0]  col_prod;
	logic [LINE_PROD_W-1:0] line_prod;
	logic                   row_end;
	logic                   frame_end;
	logic                   band_end;
	logic                   pix_left;
	logic                   req_left;
	logic                   s2_free;
	logic                   adv;

	assign pix_left = res_s2.pix_valid && !drain.pix_taken;
	assign req_left = res_s2.req_valid && !drain.req_taken;
	assign s2_free  = !pix_left && !req_left;
	assign adv      = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// constant reciprocal multiply in place of the divide
	assign col_prod  = COL_PROD_W'(cfg.source_width) * COL_PROD_W'(COL_RECIP);
	assign line_prod = LINE_PROD_W'(cfg.source_height) * LINE_PROD_W'(LINE_RECIP);

	assign row_end   = (out_column_q == COL_W'(OUT_WIDTH - 1));
	assign frame_end = row_end && (out_line_q == LINE_W'(OUT_HEIGHT - 1));
	assign band_end  = row_end && (frame_end || (band_line_q == BAND_W'(BAND_LINES - 1)));

	always_comb begin
		active_n     = active_q;
		out_column_n = out_column_q;
		out_line_n   = out_line_q;
		band_line_n  = band_line_q;
		col_acc_n    = col_acc_q;
		line_acc_n   = line_acc_q;
		col_step_n   = col_step_q;
		line_step_n  = line_step_q;
		res_n        = '0;
		case (op_s1)
			OP_START: begin
				if (cfg.source_width == '0 || cfg.source_height == '0) begin
					active_n = 1'b0;
				end else begin
					active_n      = 1'b1;
					col_step_n    = col_prod[COL_K +: COL_STEP_W];
					line_step_n   = line_prod[LINE_K +: LINE_STEP_W];
					out_column_n  = '0;
					out_line_n    = '0;
					band_line_n   = '0;
					col_acc_n     = '0;
					line_acc_n    = '0;
					res_n.req_valid = 1'b1;
				end
			end
			OP_PIXEL: begin
				if (active_q) begin
					res_n.pix_valid = 1'b1;
					res_n.pixel     = convert_pixel(pixel_s1);
					res_n.band_end  = band_end;
					res_n.frame_end = frame_end;
					if (frame_end) begin
						active_n = 1'b0;
					end else begin
						if (row_end) begin
							out_column_n = '0;
							col_acc_n    = '0;
							out_line_n   = out_line_q + LINE_W'(1);
							line_acc_n   = line_acc_q + LINE_ACC_W'(line_step_q);
							band_line_n  = (band_line_q == BAND_W'(BAND_LINES - 1)) ?
								'0 : band_line_q + BAND_W'(1);
						end else begin
							out_column_n = out_column_q + COL_W'(1);
							col_acc_n    = col_acc_q + COL_ACC_W'(col_step_q);
						end
						res_n.req_valid = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res_n.row = line_acc_n[LINE_ACC_W-1:FRAC_BITS];
		res_n.col = col_acc_n[COL_ACC_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= in_op;
			pixel_s1 <= in_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			out_column_q <= '0;
			out_line_q   <= '0;
			band_line_q  <= '0;
			col_acc_q    <= '0;
			line_acc_q   <= '0;
			col_step_q   <= '0;
			line_step_q  <= '0;
		end else if (adv) begin
			active_q     <= active_n;
			out_column_q <= out_column_n;
			out_line_q   <= out_line_n;
			band_line_q  <= band_line_n;
			col_acc_q    <= col_acc_n;
			line_acc_q   <= line_acc_n;
			col_step_q   <= col_step_n;
			line_step_q  <= line_step_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (adv) begin
			res_s2 <= res_n;
		end else begin
			res_s2.pix_valid <= pix_left;
			res_s2.req_valid <= req_left;
		end
	end

	assign res = res_s2;

endmodule

// ----- rtl/spf_result_out.sv -----
// address generation and output register for pixel and read request items
`include "assert_macros.svh"

module spf_result_out (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [spf_pkg::STRIDE_W-1:0]     line_stride,
	input  spf_pkg::res_t                    res,
	output spf_pkg::drain_t                  drain,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [spf_pkg::OUT_TDATA_W-1:0]  out_data,
	output spf_pkg::kind_t                   out_kind,
	output logic                             out_last
);
	import spf_pkg::*;

	logic                   out_free;
	logic                   take_pix;
	logic                   take_req;
	logic [ADDR_FULL_W-1:0] addr_full;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [PIXEL_W-1:0] out_pixel_q;
	logic               out_band_q;
	logic               out_frame_q;
	logic               out_last_q;

	assign out_free = !out_valid_q || out_ready;
	assign take_pix = out_free && res.pix_valid;
	assign take_req = out_free && res.req_valid && !res.pix_valid;
	assign drain    = '{pix_taken: take_pix, req_taken: take_req};

	assign addr_full = ADDR_FULL_W'(res.row) * ADDR_FULL_W'(line_stride)
		+ ADDR_FULL_W'(res.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.pix_valid || res.req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_pix) begin
			out_kind_q  <= KIND_PIX;
			out_addr_q  <= '0;
			out_pixel_q <= res.pixel;
			out_band_q  <= res.band_end;
			out_frame_q <= res.frame_end;
			out_last_q  <= res.frame_end;
		end else if (take_req) begin
			out_kind_q  <= KIND_REQ;
			out_addr_q  <= addr_full[ADDR_W-1:0];
			out_pixel_q <= '0;
			out_band_q  <= 1'b0;
			out_frame_q <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;
	assign out_data  = OUT_TDATA_W'({out_frame_q, out_band_q, out_pixel_q, out_addr_q});

	`SPF_ASSERT_IMP(a_req_fields, out_valid_q && out_kind_q == KIND_REQ, out_last_q && out_pixel_q == '0 && !out_band_q && !out_frame_q, "read request item with pixel fields set")
	`SPF_ASSERT_IMP(a_pix_addr, out_valid_q && out_kind_q == KIND_PIX, out_addr_q == '0, "pixel item with nonzero address")
	`SPF_ASSERT_IMP(a_frame_flags, out_valid_q && out_frame_q, out_band_q && out_last_q, "frame end without band end or last")
	`SPF_ASSERT_IMP(a_pix_then_req, res.pix_valid && !res.frame_end, res.req_valid, "pixel inside frame without next read request")
	`SPF_ASSERT_NXT(a_pix_to_req, take_pix && res.req_valid, res.req_valid && !res.pix_valid, "read request lost after pixel item")

endmodule

// ----- rtl/scaled_pixel_fetch_converter.sv -----
// top level of the nearest-neighbour scaled pixel fetch converter
// path: input register, result register and output register; the pixel item goes out first
// and its read request after it, both through the single output register
// throughput: starts one per cycle if not stalled; a pixel waits for the prior read request
// reset: asynchronous, idle, registers to 320 x 240 and stride 1024, no clearing pass
module scaled_pixel_fetch_converter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [spf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [spf_pkg::PIXEL_W-1:0]      s_axis_tdata,  // pixel_in
	input  logic                             s_axis_tuser,  // operation
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [spf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // read_address, pixel_out, band_end, frame_end
	output logic                             m_axis_tuser,  // kind
	output logic                             m_axis_tlast
);
	import spf_pkg::*;

	cfg_t   cfg;
	res_t   res;
	drain_t drain;
	kind_t  kind;

	spf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spf_frame_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (op_t'(s_axis_tuser)),
		.in_pixel (s_axis_tdata),
		.drain    (drain),
		.res      (res)
	);

	spf_result_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_stride (cfg.line_stride),
		.res         (res),
		.drain       (drain),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_kind    (kind),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tuser = kind;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench for the scaled pixel fetch converter: directed table, random frames, long frame runs
module tb;
	import spf_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [PIXEL_W-1:0] pix;
		logic               band;
		logic               frame;
		logic               last;
	} fetch_result_t;

	typedef enum logic {
		ACT_ITEM = 1'b0,
		ACT_REG  = 1'b1
	} action_t;

	typedef struct packed {
		action_t                act;
		op_t                    op;
		logic [PIXEL_W-1:0]     pix;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  val;
		logic                   typed;
		logic [1:0]             n;
		fetch_result_t          r0;
		fetch_result_t          r1;
	} script_row_t;

	localparam fetch_result_t NO_RES = '0;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [PIXEL_W-1:0]      s_axis_tdata = '0;
	logic                    s_axis_tuser = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    m_axis_tuser;
	logic                    m_axis_tlast;

	scaled_pixel_fetch_converter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// scaler state as seen from outside
	logic [SRC_WIDTH_W-1:0]  width_reg = SRC_WIDTH_RST;
	logic [SRC_HEIGHT_W-1:0] height_reg = SRC_HEIGHT_RST;
	logic [STRIDE_W-1:0]     stride_reg = STRIDE_RST;
	logic                    raster_running = 1'b0;
	int unsigned             col_idx = 0;
	int unsigned             line_idx = 0;
	int unsigned             col_acc = 0;
	int unsigned             line_acc = 0;
	int unsigned             col_step = 0;
	int unsigned             line_step = 0;

	fetch_result_t step_out [2];
	int            step_n;
	fetch_result_t awaited [$];
	script_row_t   script [$];

	int send_idle = 0;
	int recv_idle = 0;
	int items_sent = 0;
	int faults = 0;

	function automatic fetch_result_t want_req(input logic [ADDR_W-1:0] a);
		return '{KIND_REQ, a, 16'd0, 1'b0, 1'b0, 1'b1};
	endfunction

	function automatic fetch_result_t want_pix(input logic [PIXEL_W-1:0] p);
		return '{KIND_PIX, 20'd0, p, 1'b0, 1'b0, 1'b0};
	endfunction

	function automatic script_row_t row_item(input op_t op, input logic [PIXEL_W-1:0] p,
		input logic typed, input logic [1:0] n, input fetch_result_t r0,
		input fetch_result_t r1);
		return '{ACT_ITEM, op, p, REG_SOURCE_WIDTH, 12'd0, typed, n, r0, r1};
	endfunction

	function automatic script_row_t row_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		return '{ACT_REG, OP_START, 16'd0, idx, val, 1'b0, 2'd0, NO_RES, NO_RES};
	endfunction

	function automatic logic [PIXEL_W-1:0] to_565_swapped(input logic [PIXEL_W-1:0] c);
		logic [4:0]         red;
		logic [5:0]         green;
		logic [4:0]         blue;
		logic [PIXEL_W-1:0] v;
		red   = c[4:0];
		green = {c[9:5], c[9]};
		blue  = c[14:10];
		v     = {blue, green, red};
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [ADDR_W-1:0] source_index();
		longint unsigned row;
		longint unsigned col;
		row = longint'(line_acc >> FRAC_BITS);
		col = longint'(col_acc >> FRAC_BITS);
		return ADDR_W'(row * longint'(stride_reg) + col);
	endfunction

	function automatic void store_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_SOURCE_WIDTH:  width_reg = val[SRC_WIDTH_W-1:0];
			REG_SOURCE_HEIGHT: height_reg = val[SRC_HEIGHT_W-1:0];
			REG_LINE_STRIDE:   stride_reg = val[STRIDE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void advance_raster(input op_t op, input logic [PIXEL_W-1:0] p);
		logic row_end;
		logic frame_done;
		logic band_done;
		step_n = 0;
		if (op == OP_START) begin
			if (width_reg == 0 || height_reg == 0) begin
				raster_running = 1'b0;
				return;
			end
			col_step = (32'(width_reg) << FRAC_BITS) / OUT_WIDTH;
			line_step = (32'(height_reg) << FRAC_BITS) / OUT_HEIGHT;
			col_idx = 0;
			line_idx = 0;
			col_acc = 0;
			line_acc = 0;
			raster_running = 1'b1;
			step_out[0] = want_req(source_index());
			step_n = 1;
			return;
		end
		if (!raster_running)
			return;
		row_end = (col_idx + 1 >= OUT_WIDTH);
		frame_done = row_end && (line_idx + 1 >= OUT_HEIGHT);
		band_done = row_end && (frame_done || ((line_idx + 1) % BAND_LINES) == 0);
		step_out[0] = '{KIND_PIX, 20'd0, to_565_swapped(p), band_done, frame_done, frame_done};
		step_n = 1;
		if (frame_done) begin
			raster_running = 1'b0;
			return;
		end
		if (row_end) begin
			col_idx = 0;
			col_acc = 0;
			line_idx++;
			line_acc += line_step;
		end else begin
			col_idx++;
			col_acc += col_step;
		end
		step_out[1] = want_req(source_index());
		step_n = 2;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		case ($urandom_range(7))
			0: return 12'd1;
			1: return 12'd1024;
			2: return 12'hFFF;
			3: return 12'd320;
			default: return 12'($urandom_range(4095, 1));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_height();
		case ($urandom_range(7))
			0: return 12'd1;
			1: return 12'd512;
			2: return 12'd1023;
			3: return 12'd240;
			default: return 12'($urandom_range(4095, 1));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_stride();
		case ($urandom_range(7))
			0: return 12'd0;
			1: return 12'd1;
			2: return 12'd2048;
			3: return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic send_item(input op_t op, input logic [PIXEL_W-1:0] p, input bit typed);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= p;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		advance_raster(op, p);
		if (!typed)
			for (int k = 0; k < step_n; k++)
				awaited.push_back(step_out[k]);
	endtask

	// sender holds off until every result is back and the pipeline is empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		store_register(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_frame(input logic [CFG_DATA_W-1:0] w,
		input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] s);
		settle();
		write_register(REG_SOURCE_WIDTH, w);
		write_register(REG_SOURCE_HEIGHT, h);
		write_register(REG_LINE_STRIDE, s);
	endtask

	task automatic run_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
		input logic [CFG_DATA_W-1:0] s, input int pixels);
		program_frame(w, h, s);
		send_item(OP_START, 16'($urandom), 1'b0);
		repeat (pixels) send_item(OP_PIXEL, 16'($urandom), 1'b0);
	endtask

	task automatic run_sequences(input int budget);
		int target;
		int r;
		int n;
		target = items_sent + budget;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 6) begin
				send_item(OP_PIXEL, 16'($urandom), 1'b0);
			end else if (r < 10) begin
				settle();
				write_register($urandom_range(1) ? REG_SOURCE_WIDTH : REG_SOURCE_HEIGHT, '0);
				send_item(OP_START, 16'($urandom), 1'b0);
			end else begin
				program_frame(pick_width(), pick_height(), pick_stride());
				send_item(OP_START, 16'($urandom), 1'b0);
				n = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(40, 1);
				for (int k = 0; k < n; k++) begin
					if (k == n / 2 && $urandom_range(7) == 0) begin
						settle();
						write_register(REG_LINE_STRIDE, pick_stride());
					end
					send_item(OP_PIXEL, 16'($urandom), 1'b0);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		fetch_result_t seen;
		fetch_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			seen = '{kind_t'(m_axis_tuser), m_axis_tdata[ADDR_W-1:0],
				m_axis_tdata[ADDR_W +: PIXEL_W], m_axis_tdata[ADDR_W+PIXEL_W],
				m_axis_tdata[ADDR_W+PIXEL_W+1], m_axis_tlast};
			if (awaited.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected item: kind %0d addr %05h pix %04h band %0d frame %0d last %0d",
						seen.kind, seen.addr, seen.pix, seen.band, seen.frame, seen.last);
			end else begin
				want = awaited.pop_front();
				if (seen !== want) begin
					faults++;
					if (faults <= 10)
						$display("mismatch at %0t: expected %0d %05h %04h %0d %0d %0d, got %0d %05h %04h %0d %0d %0d",
							$time, want.kind, want.addr, want.pix, want.band, want.frame,
							want.last, seen.kind, seen.addr, seen.pix, seen.band, seen.frame,
							seen.last);
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		script = '{
			row_item(OP_PIXEL, 16'hFFFF, 1'b1, 2'd0, NO_RES, NO_RES),
			row_item(OP_START, 16'h0000, 1'b1, 2'd1, want_req(20'd0), NO_RES),
			row_item(OP_PIXEL, 16'h7FFF, 1'b1, 2'd2, want_pix(16'hFFFF), want_req(20'd1)),
			row_item(OP_PIXEL, 16'h8000, 1'b1, 2'd2, want_pix(16'h0000), want_req(20'd2)),
			row_item(OP_PIXEL, 16'h001F, 1'b1, 2'd2, want_pix(16'h1F00), want_req(20'd3)),
			row_item(OP_PIXEL, 16'h03E0, 1'b1, 2'd2, want_pix(16'hE007), want_req(20'd4)),
			row_item(OP_PIXEL, 16'h0200, 1'b1, 2'd2, want_pix(16'h2004), want_req(20'd5)),
			row_item(OP_PIXEL, 16'h7C00, 1'b1, 2'd2, want_pix(16'h00F8), want_req(20'd6)),
			row_item(OP_START, 16'h1234, 1'b1, 2'd1, want_req(20'd0), NO_RES),
			row_item(OP_PIXEL, 16'h0020, 1'b1, 2'd2, want_pix(16'h4000), want_req(20'd1)),
			row_reg(REG_SOURCE_WIDTH, 12'd0),
			row_item(OP_START, 16'h0000, 1'b1, 2'd0, NO_RES, NO_RES),
			row_item(OP_PIXEL, 16'h7FFF, 1'b1, 2'd0, NO_RES, NO_RES),
			row_reg(REG_SOURCE_WIDTH, 12'hFFF),
			row_reg(REG_SOURCE_HEIGHT, 12'hFFF),
			row_reg(REG_LINE_STRIDE, 12'hFFF),
			row_item(OP_START, 16'hFFFF, 1'b1, 2'd1, want_req(20'd0), NO_RES),
			row_item(OP_PIXEL, 16'h5555, 1'b0, 2'd0, NO_RES, NO_RES),
			row_item(OP_PIXEL, 16'hAAAA, 1'b0, 2'd0, NO_RES, NO_RES),
			row_reg(REG_LINE_STRIDE, 12'd0),
			row_item(OP_PIXEL, 16'h0F0F, 1'b0, 2'd0, NO_RES, NO_RES),
			row_reg(REG_SOURCE_HEIGHT, 12'd0),
			row_item(OP_START, 16'h0000, 1'b1, 2'd0, NO_RES, NO_RES),
			row_reg(REG_SOURCE_WIDTH, 12'd1),
			row_reg(REG_SOURCE_HEIGHT, 12'd1),
			row_reg(REG_LINE_STRIDE, 12'd1),
			row_item(OP_START, 16'h0000, 1'b1, 2'd1, want_req(20'd0), NO_RES),
			row_item(OP_PIXEL, 16'h6B5A, 1'b0, 2'd0, NO_RES, NO_RES),
			row_reg(REG_SOURCE_WIDTH, 12'd1024),
			row_reg(REG_SOURCE_HEIGHT, 12'd512),
			row_reg(REG_LINE_STRIDE, 12'd2048),
			row_item(OP_START, 16'h0000, 1'b1, 2'd1, want_req(20'd0), NO_RES),
			row_item(OP_PIXEL, 16'hC3C3, 1'b0, 2'd0, NO_RES, NO_RES),
			row_item(OP_PIXEL, 16'h3C3C, 1'b0, 2'd0, NO_RES, NO_RES)
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 15;
		recv_idle = 59;
		foreach (script[i]) begin
			if (script[i].act == ACT_REG) begin
				settle();
				write_register(script[i].idx, script[i].val);
			end else begin
				send_item(script[i].op, script[i].pix, script[i].typed);
				if (script[i].typed && script[i].n >= 1)
					awaited.push_back(script[i].r0);
				if (script[i].typed && script[i].n == 2)
					awaited.push_back(script[i].r1);
			end
		end
		run_sequences(230);
		// twice the output size under heavy back-pressure
		run_frame(12'd640, 12'd480, 12'd2048, 40);

		send_idle = 59;
		recv_idle = 15;
		run_sequences(230);

		send_idle = 0;
		recv_idle = 0;
		run_sequences(230);
		// largest source, running past the end of the first output line
		run_frame(12'hFFF, 12'hFFF, 12'hFFF, OUT_WIDTH + 8);
		send_item(OP_PIXEL, 16'hFFFF, 1'b0);
		settle();
		repeat (10) @(posedge clk);

		if (faults == 0 && awaited.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/spf_pkg.sv
rtl/spf_cfg_regs.sv
rtl/spf_frame_walker.sv
rtl/spf_result_out.sv
rtl/scaled_pixel_fetch_converter.sv
tb/tb.sv
